@@ src/slwm_pkg.sv @@
// Shared types for the sliding-window minimum unit.
// Holds the control bundle broadcast from the top level to every queue cell.
// No dependencies.
package slwm_pkg;

	typedef struct packed {
		logic step;
		logic shift;
		logic clear;
	} cell_ctl_t;

endpackage

@@ src/slwm_cell.sv @@
// One slot of the monotonic candidate queue: value, age and occupancy.
// Takes its neighbor's content on a front drop and appends the new sample.
// Depends on slwm_pkg for the control bundle.
module slwm_cell #(
	parameter int SAMPLE_WIDTH = 32,
	parameter int AGE_W        = 6
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  slwm_pkg::cell_ctl_t            ctl,
	input  logic signed [SAMPLE_WIDTH-1:0] sample,
	input  logic signed [SAMPLE_WIDTH-1:0] nb_val,
	input  logic        [AGE_W-1:0]        nb_age,
	input  logic                           nb_valid,
	input  logic                           prev_kept,
	output logic signed [SAMPLE_WIDTH-1:0] val,
	output logic        [AGE_W-1:0]        age,
	output logic                           valid,
	output logic                           kept,
	output logic signed [SAMPLE_WIDTH-1:0] nxt_val
);

	logic signed [SAMPLE_WIDTH-1:0] val_q;
	logic        [AGE_W-1:0]        age_q;
	logic                           valid_q;
	logic signed [SAMPLE_WIDTH-1:0] sh_val;
	logic        [AGE_W-1:0]        sh_age;
	logic                           sh_valid;

	assign sh_val   = ctl.shift ? nb_val   : val_q;
	assign sh_age   = ctl.shift ? nb_age   : age_q;
	assign sh_valid = ctl.shift ? nb_valid : valid_q;
	assign kept     = sh_valid && !(sh_val > sample);
	assign nxt_val  = kept ? sh_val : sample;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.step && ctl.clear) begin
			valid_q <= 1'b0;
		end else if (ctl.step) begin
			valid_q <= kept || prev_kept;
		end else if (ctl.shift) begin
			valid_q <= sh_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.step) begin
			if (kept) begin
				val_q <= sh_val;
				age_q <= sh_age + AGE_W'(1);
			end else begin
				val_q <= sample;
				age_q <= '0;
			end
		end else if (ctl.shift) begin
			val_q <= sh_val;
			age_q <= sh_age;
		end
	end

	assign val   = val_q;
	assign age   = age_q;
	assign valid = valid_q;

endmodule

@@ src/sliding_window_minimum_unit.sv @@
// Sliding-window minimum filter: top level with the cell row and output register.
// Instantiates slwm_cell and uses slwm_pkg.
//
// The unit takes one sample per clock while in_ready is high and, once the
// current sequence holds window_size samples, returns the minimum of the
// last window_size samples in the cycle after the sample's transaction,
// from a single output register. While that register holds a result that
// has not been taken, in_ready stays low, so the next sample enters at the
// earliest in the cycle that the result leaves. Candidates live in a row of
// WINDOW_MAX cells, each comparing its value with the incoming sample and
// taking its neighbor's content when the oldest candidate leaves the window.
// A write of window_size holds in_ready low until the row has dropped, from
// the front, every stored candidate that the new window ages out.
// A window_size of 0 acts as 1, and one above WINDOW_MAX acts as WINDOW_MAX.
module sliding_window_minimum_unit #(
	parameter int WINDOW_MAX   = 64,
	parameter int SAMPLE_WIDTH = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [SAMPLE_WIDTH-1:0]       sample,
	input  logic                                 end_of_sequence,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [SAMPLE_WIDTH-1:0]       window_min,
	output logic                                 last_result,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [$clog2(WINDOW_MAX+1)-1:0]      window_size
);

	localparam int WIN_W = $clog2(WINDOW_MAX + 1);
	localparam int AGE_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

	logic [WIN_W-1:0]               win_q;
	logic [WIN_W-1:0]               w_eff;
	logic [WIN_W-1:0]               seen_q;
	logic [WIN_W-1:0]               seen_next;
	logic                           trim_q;
	logic                           out_valid_q;
	logic signed [SAMPLE_WIDTH-1:0] window_min_q;
	logic                           last_result_q;
	logic                           in_fire;
	logic                           cfg_fire;
	logic                           front_drop;
	logic                           produce;
	slwm_pkg::cell_ctl_t            ctl;

	logic signed [SAMPLE_WIDTH-1:0] c_val   [WINDOW_MAX+1];
	logic        [AGE_W-1:0]        c_age   [WINDOW_MAX+1];
	logic        [WINDOW_MAX:0]     c_valid;
	logic        [WINDOW_MAX:0]     k_chain;
	logic signed [SAMPLE_WIDTH-1:0] front_next;

	always_comb begin
		if (win_q == '0) begin
			w_eff = WIN_W'(1);
		end else if (win_q > WIN_W'(WINDOW_MAX)) begin
			w_eff = WIN_W'(WINDOW_MAX);
		end else begin
			w_eff = win_q;
		end
	end

	assign cfg_ready  = 1'b1;
	assign cfg_fire   = cfg_valid && cfg_ready;
	assign in_ready   = !trim_q && (!out_valid_q || out_ready);
	assign in_fire    = in_valid && in_ready;
	assign front_drop = c_valid[0] && ((WIN_W'(c_age[0]) + WIN_W'(1)) >= w_eff);

	assign ctl.step  = in_fire;
	assign ctl.shift = (in_fire || trim_q) && front_drop;
	assign ctl.clear = end_of_sequence;

	assign seen_next = (seen_q < WIN_W'(WINDOW_MAX)) ? seen_q + WIN_W'(1) : seen_q;
	assign produce   = seen_next >= w_eff;

	assign c_val[WINDOW_MAX]   = '0;
	assign c_age[WINDOW_MAX]   = '0;
	assign c_valid[WINDOW_MAX] = 1'b0;
	assign k_chain[0]          = 1'b1;

	for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
		if (i == 0) begin : g_front
			slwm_cell #(
				.SAMPLE_WIDTH(SAMPLE_WIDTH),
				.AGE_W(AGE_W)
			) u_cell (
				.clk(clk),
				.arst_n(arst_n),
				.ctl(ctl),
				.sample(sample),
				.nb_val(c_val[i+1]),
				.nb_age(c_age[i+1]),
				.nb_valid(c_valid[i+1]),
				.prev_kept(k_chain[i]),
				.val(c_val[i]),
				.age(c_age[i]),
				.valid(c_valid[i]),
				.kept(k_chain[i+1]),
				.nxt_val(front_next)
			);
		end else begin : g_rest
			slwm_cell #(
				.SAMPLE_WIDTH(SAMPLE_WIDTH),
				.AGE_W(AGE_W)
			) u_cell (
				.clk(clk),
				.arst_n(arst_n),
				.ctl(ctl),
				.sample(sample),
				.nb_val(c_val[i+1]),
				.nb_age(c_age[i+1]),
				.nb_valid(c_valid[i+1]),
				.prev_kept(k_chain[i]),
				.val(c_val[i]),
				.age(c_age[i]),
				.valid(c_valid[i]),
				.kept(k_chain[i+1]),
				.nxt_val()
			);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q       <= WIN_W'(1);
			trim_q      <= 1'b0;
			seen_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_fire) begin
				win_q  <= window_size;
				trim_q <= 1'b1;
			end else if (trim_q && !front_drop) begin
				trim_q <= 1'b0;
			end
			if (in_fire) begin
				seen_q <= end_of_sequence ? '0 : seen_next;
			end
			if (in_fire && produce) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && produce) begin
			window_min_q  <= front_next;
			last_result_q <= end_of_sequence;
		end
	end

	assign out_valid   = out_valid_q;
	assign window_min  = window_min_q;
	assign last_result = last_result_q;

	// Occupied cells always form a prefix of the row.
	assert property (@(posedge clk) disable iff (!arst_n)
		((c_valid >> 1) & ~c_valid) == '0)
		else $error("queue occupancy is not a prefix");

	assert property (@(posedge clk) disable iff (!arst_n)
		seen_q <= WIN_W'(WINDOW_MAX))
		else $error("sample count exceeds the window limit");

	assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && produce |=> out_valid)
		else $error("accepted transaction lost its result");

	assert property (@(posedge clk) disable iff (!arst_n)
		trim_q && !front_drop && !cfg_fire |=> !trim_q)
		else $error("window trim did not finish");

endmodule

@@ tb/sliding_window_minimum_unit_tb.sv @@
// Testbench for sliding_window_minimum_unit: drives samples and window writes,
// predicts each window minimum in a scoreboard class and checks every result.
// Depends only on the RTL of the unit.
`timescale 1ns / 1ps

localparam int QUEUE_DEPTH = 64;
localparam int SAMPLE_BITS = 32;

typedef struct {
	logic signed [SAMPLE_BITS-1:0] value;
	logic                          last;
} min_result_t;

class window_min_scoreboard;
	int unsigned                   window_reg;
	logic signed [SAMPLE_BITS-1:0] cand_value [QUEUE_DEPTH];
	int                            cand_age [QUEUE_DEPTH];
	int                            cand_count;
	int                            seq_samples;
	int                            errors;
	min_result_t                   expected_mins [$];

	function new();
		window_reg  = 1;
		cand_count  = 0;
		seq_samples = 0;
		errors      = 0;
	endfunction

	function void set_window(logic [6:0] v);
		window_reg = 32'(v);
	endfunction

	function int pending();
		return expected_mins.size();
	endfunction

	function void note_sample(logic signed [SAMPLE_BITS-1:0] s, logic eos);
		int          span;
		min_result_t r;
		span = window_reg;
		if (span < 1) span = 1;
		if (span > QUEUE_DEPTH) span = QUEUE_DEPTH;
		for (int i = 0; i < cand_count; i++) cand_age[i]++;
		while (cand_count > 0 && cand_age[0] >= span) begin
			for (int i = 0; i + 1 < cand_count; i++) begin
				cand_value[i] = cand_value[i + 1];
				cand_age[i]   = cand_age[i + 1];
			end
			cand_count--;
		end
		while (cand_count > 0 && cand_value[cand_count - 1] > s) cand_count--;
		cand_value[cand_count] = s;
		cand_age[cand_count]   = 0;
		cand_count++;
		if (seq_samples < QUEUE_DEPTH) seq_samples++;
		if (seq_samples >= span) begin
			r.value = cand_value[0];
			r.last  = eos;
			expected_mins.insert(expected_mins.size(), r);
		end
		if (eos) begin
			cand_count  = 0;
			seq_samples = 0;
		end
	endfunction

	function void check_result(logic signed [SAMPLE_BITS-1:0] v, logic last);
		min_result_t e;
		if (expected_mins.size() == 0) begin
			$display("%0t unexpected result: expected none actual window_min=%0d last_result=%0b",
				$time, v, last);
			errors++;
			return;
		end
		e = expected_mins[0];
		expected_mins.delete(0);
		if (v !== e.value) begin
			$display("%0t window_min mismatch: expected %0d actual %0d", $time, e.value, v);
			errors++;
		end
		if (last !== e.last) begin
			$display("%0t last_result mismatch: expected %0b actual %0b", $time, e.last, last);
			errors++;
		end
	endfunction
endclass

module sliding_window_minimum_unit_tb;

	typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;
	typedef enum {VAL_FULL, VAL_NARROW, VAL_EXTREME, VAL_RISING, VAL_FALLING} value_style_t;

	localparam int RANDOM_ITEMS = 1850;

	logic                          clk;
	logic                          arst_n = 1'b0;
	logic                          in_valid = 1'b0;
	logic                          in_ready;
	logic signed [SAMPLE_BITS-1:0] sample = '0;
	logic                          end_of_sequence = 1'b0;
	logic                          out_valid;
	logic                          out_ready = 1'b0;
	logic signed [SAMPLE_BITS-1:0] window_min;
	logic                          last_result;
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic [6:0]                    window_size = '0;

	window_min_scoreboard sb = new();
	int                   items_sent = 0;
	int                   burst_left = 0;
	bit                   sender_steady = 1'b0;

	sliding_window_minimum_unit #(
		.WINDOW_MAX  (QUEUE_DEPTH),
		.SAMPLE_WIDTH(SAMPLE_BITS)
	) uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.sample         (sample),
		.end_of_sequence(end_of_sequence),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.window_min     (window_min),
		.last_result    (last_result),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.window_size    (window_size)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	always @(posedge clk) begin
		if (cfg_valid && cfg_ready) sb.set_window(window_size);
		if (in_valid && in_ready) sb.note_sample(sample, end_of_sequence);
		if (out_valid && out_ready) sb.check_result(window_min, last_result);
	end

	initial begin : receiver
		rx_mode_t mode;
		int       span;
		forever begin
			mode = rx_mode_t'($urandom_range(0, 3));
			span = $urandom_range(16, 160);
			for (int k = 0; k < span; k++) begin
				@(posedge clk);
				case (mode)
					RX_OPEN:   out_ready <= 1'b1;
					RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
					RX_SPARSE: out_ready <= ($urandom_range(0, 7) == 0);
					default:   out_ready <= (k % 4 != 3);
				endcase
			end
		end
	end

	initial begin
		#5_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] s, input logic eos);
		int gap;
		if (burst_left == 0) begin
			gap = (sender_steady || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		in_valid        <= 1'b1;
		sample          <= s;
		end_of_sequence <= eos;
		do @(posedge clk); while (!in_ready);
		items_sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		burst_left = 0;
		@(negedge clk);
		while (sb.pending() != 0) @(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_window(input logic [6:0] v);
		drain();
		cfg_valid   <= 1'b1;
		window_size <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [6:0] pick_window();
		case ($urandom_range(0, 9))
			0:       return 7'd0;
			1:       return 7'd1;
			2:       return 7'd64;
			3:       return 7'($urandom_range(65, 127));
			4, 5, 6: return 7'($urandom_range(2, 8));
			default: return 7'($urandom_range(1, 64));
		endcase
	endfunction

	function automatic int effective_window(input logic [6:0] v);
		if (v < 1) return 1;
		if (v > QUEUE_DEPTH) return QUEUE_DEPTH;
		return int'(v);
	endfunction

	task automatic send_sequence(input int len);
		value_style_t                  style;
		logic signed [SAMPLE_BITS-1:0] ramp;
		logic signed [SAMPLE_BITS-1:0] s;
		int                            split_at;
		style    = value_style_t'($urandom_range(0, 4));
		ramp     = $urandom;
		split_at = (len > 1 && $urandom_range(0, 4) == 0) ? $urandom_range(1, len - 1) : -1;
		for (int i = 0; i < len; i++) begin
			if (i == split_at) write_window(pick_window());
			case (style)
				VAL_FULL:   s = $urandom;
				VAL_NARROW: s = $signed($urandom_range(0, 16)) - 8;
				VAL_EXTREME: begin
					case ($urandom_range(0, 4))
						0:       s = 32'sh8000_0000;
						1:       s = 32'sh7FFF_FFFF;
						2:       s = -1;
						3:       s = 0;
						default: s = 1;
					endcase
				end
				VAL_RISING: begin
					ramp = ramp + $urandom_range(0, 3);
					s    = ramp;
				end
				default: begin
					ramp = ramp - $urandom_range(0, 3);
					s    = ramp;
				end
			endcase
			send_sample(s, i == len - 1);
		end
	endtask

	initial begin : stimulus
		logic [6:0] win;
		int         eff;
		int         len;
		int         goal;
		int         r;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Window of one after reset, extremes of the sample range.
		send_sample(32'sh7FFF_FFFF, 1'b0);
		send_sample(32'sh8000_0000, 1'b0);
		send_sample(0, 1'b1);
		// A window of zero behaves as one.
		write_window(7'd0);
		send_sample(-1, 1'b1);
		// Oversized window on a short sequence gives no result.
		write_window(7'd127);
		send_sample(5, 1'b0);
		send_sample(-5, 1'b1);
		// Equal samples keep the earlier one as a candidate.
		write_window(7'd3);
		send_sample(4, 1'b0);
		send_sample(4, 1'b0);
		send_sample(9, 1'b0);
		send_sample(2, 1'b1);
		// Window shrinks and then grows in the middle of a sequence.
		write_window(7'd4);
		send_sample(1, 1'b0);
		send_sample(8, 1'b0);
		send_sample(9, 1'b0);
		send_sample(10, 1'b0);
		write_window(7'd2);
		send_sample(11, 1'b0);
		write_window(7'd5);
		send_sample(12, 1'b1);

		goal = items_sent + RANDOM_ITEMS;
		while (items_sent < goal) begin
			win = pick_window();
			write_window(win);
			sender_steady = ($urandom_range(0, 3) == 0);
			repeat ($urandom_range(1, 4)) begin
				eff = effective_window(7'(sb.window_reg));
				r   = $urandom_range(0, 9);
				if (r == 0) len = $urandom_range(1, eff);
				else if (r <= 6) len = eff + $urandom_range(0, 12);
				else len = eff + $urandom_range(13, 90);
				send_sequence(len);
			end
		end

		drain();
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
